>>> rtl/hpm_pkg.sv
package hpm_pkg;

	localparam int FORCE_WIDTH_DEF = 16;
	localparam int ALPHA_W         = 16;
	localparam int CFG_IDX_W       = 8;
	localparam int CFG_DATA_W      = 16;
	localparam int AXES            = 3;

	typedef enum logic [1:0] {
		MODE_ZERO   = 2'd0,
		MODE_ADD    = 2'd1,
		MODE_HP     = 2'd2,
		MODE_HP_UNI = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE  = 8'd0,
		REG_ALPHA = 8'd1
	} reg_idx_t;

	localparam mode_t               MODE_RESET  = MODE_ADD;
	localparam logic [ALPHA_W-1:0]  ALPHA_RESET = 16'd61663;

	// per-lane filter control
	typedef struct packed {
		logic update;
		logic uni;
	} hpm_ctl_t;

endpackage

>>> rtl/three_axis_force_highpass_mixer_unit.sv
// channel        | dir | handshake                    | payload
// s_axis         | in  | s_axis_tvalid/s_axis_tready  | contact x,y,z then guide x,y,z
// m_axis         | out | m_axis_tvalid/m_axis_tready  | feedback x,y,z
// cfg            | in  | cfg_valid/cfg_ready          | cfg_index, cfg_data
//
// One request per cycle unless m_axis stalls; stage 1 feeds the output register.
// Each axis lane's filter recurrence (add, alpha multiply, saturate) is combinational.
// Reset: mode add, alpha 61663, filter state zero, first-sample flags set.
// A stalled m_axis holds the output register, then stage 1, then drops s_axis_tready.
// cfg_ready is always high.
module three_axis_force_highpass_mixer_unit import hpm_pkg::*; #(
	parameter int FORCE_WIDTH = FORCE_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// contact_x, contact_y, contact_z, guide_x, guide_y, guide_z (low first), zero pad
	input  logic [((6*FORCE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// feedback_x, feedback_y, feedback_z (low first), zero pad
	output logic [((3*FORCE_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]                  cfg_index,
	input  logic [CFG_DATA_W-1:0]                 cfg_data
);

	localparam int W = FORCE_WIDTH;

	mode_t                  mode_q;
	logic [ALPHA_W-1:0]     alpha_q;

	logic                   accept;
	logic                   out_ready;
	logic                   v_s1;
	mode_t                  mode_s1;
	logic [AXES-1:0][W-1:0] contact_s1, guide_s1;
	logic [AXES-1:0][W-1:0] contact_in, guide_in;
	logic [AXES-1:0][W+1:0] filt;
	logic [AXES-1:0][W-1:0] out_data;
	hpm_ctl_t               ctl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_RESET;
			alpha_q <= ALPHA_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE:  mode_q  <= mode_t'(cfg_data[1:0]);
				REG_ALPHA: alpha_q <= cfg_data[ALPHA_W-1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			contact_in[i] = s_axis_tdata[i*W +: W];
			guide_in[i]   = s_axis_tdata[(i+AXES)*W +: W];
		end
	end

	assign s_axis_tready = !v_s1 || out_ready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign ctl.update    = accept && (mode_q == MODE_HP || mode_q == MODE_HP_UNI);
	assign ctl.uni       = (mode_q == MODE_HP_UNI);

	genvar g;
	generate
		for (g = 0; g < AXES; g++) begin : g_lane
			hpm_lane #(.W(W)) u_lane (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.alpha   (alpha_q),
				.contact (contact_in[g]),
				.filt    (filt[g])
			);
		end
	endgenerate

	// stage 1: lanes hold the fresh filter output, contact/guide ride alongside
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1    <= mode_q;
			contact_s1 <= contact_in;
			guide_s1   <= guide_in;
		end
	end

	hpm_out #(.W(W)) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (out_ready),
		.mode      (mode_s1),
		.contact   (contact_s1),
		.guide     (guide_s1),
		.filt      (filt),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_data)
	);

	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[AXES*W-1:0] = out_data;
	end

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
		else $error("input taken while both stages are full and stalled");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("accepted request missing from stage 1");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !out_ready) |=> (v_s1 && $stable(contact_s1) && $stable(guide_s1)))
		else $error("stage 1 changed while stalled");

endmodule

>>> rtl/hpm_lane.sv
module hpm_lane import hpm_pkg::*; #(
	parameter int W = FORCE_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hpm_ctl_t             ctl,
	input  logic [ALPHA_W-1:0]   alpha,
	input  logic signed [W-1:0]  contact,
	output logic signed [W+1:0]  filt
);

	localparam int SW = W + 3;
	localparam int PW = SW + ALPHA_W + 1;

	logic signed [W-1:0]  prev_in_q;
	logic signed [W+1:0]  prev_out_q;
	logic                 first_q;

	logic signed [W:0]    in_ext, prev_ext;
	logic [W:0]           mag_in, mag_prev;
	logic                 restart;
	logic signed [W-1:0]  base;
	logic signed [SW-1:0] diff, operand;
	logic signed [PW-1:0] prod;
	logic signed [W+3:0]  scaled;
	logic signed [W+1:0]  sat_out;

	always_comb begin
		in_ext   = {contact[W-1], contact};
		prev_ext = {prev_in_q[W-1], prev_in_q};
		mag_in   = in_ext[W] ? $unsigned(-in_ext) : $unsigned(in_ext);
		mag_prev = prev_ext[W] ? $unsigned(-prev_ext) : $unsigned(prev_ext);
		// unidirectional mode restarts unless the magnitude grows
		restart  = ctl.uni && !(mag_prev < mag_in);
		base     = first_q ? contact : prev_in_q;
		diff     = SW'(prev_out_q) + SW'(contact) - SW'(base);
		operand  = restart ? SW'(contact) : diff;
		prod     = PW'($signed({1'b0, alpha})) * PW'(operand);
		// arithmetic shift: floor toward minus infinity
		scaled   = $signed(prod[PW-1:ALPHA_W]);
		if (scaled[W+3:W+1] == 3'b000 || scaled[W+3:W+1] == 3'b111) begin
			sat_out = scaled[W+1:0];
		end else begin
			sat_out = {scaled[W+3], {(W+1){~scaled[W+3]}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_in_q  <= '0;
			prev_out_q <= '0;
			first_q    <= 1'b1;
		end else if (ctl.update) begin
			prev_in_q  <= contact;
			prev_out_q <= sat_out;
			if (!restart) begin
				first_q <= 1'b0;
			end
		end
	end

	assign filt = prev_out_q;

endmodule

>>> rtl/hpm_out.sv
module hpm_out import hpm_pkg::*; #(
	parameter int W = FORCE_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  mode_t                        mode,
	input  logic [AXES-1:0][W-1:0]       contact,
	input  logic [AXES-1:0][W-1:0]       guide,
	input  logic [AXES-1:0][W+1:0]       filt,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [AXES-1:0][W-1:0]       out_data
);

	logic [AXES-1:0][W-1:0] mix;
	logic                   valid_q;
	logic [AXES-1:0][W-1:0] data_q;

	always_comb begin
		logic signed [W+2:0] a;
		logic signed [W+2:0] sum;
		for (int i = 0; i < AXES; i++) begin
			if (mode == MODE_ADD) begin
				a = (W+3)'($signed(contact[i]));
			end else begin
				a = (W+3)'($signed(filt[i]));
			end
			sum = a + (W+3)'($signed(guide[i]));
			if (mode == MODE_ZERO) begin
				mix[i] = '0;
			end else if (sum[W+2:W-1] == '0 || sum[W+2:W-1] == '1) begin
				mix[i] = sum[W-1:0];
			end else begin
				mix[i] = {sum[W+2], {(W-1){~sum[W+2]}}};
			end
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= mix;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule
